// ===== sv/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit allocator package
// Table sizes, status and opcode values, and the write records passed
// between the sequencer and its tables.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int FREE_ENTRIES   = 32;
  localparam int BLOCK_ENTRIES  = 32;
  localparam int MAX_POOL_BYTES = 65536;

  localparam int SEG_IDX_W = $clog2(FREE_ENTRIES);
  localparam int BLK_IDX_W = $clog2(BLOCK_ENTRIES);
  localparam int SEG_CNT_W = $clog2(FREE_ENTRIES + 1);

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_INIT  = 2'd2;

  localparam logic CFG_POOL_SIZE   = 1'b0;
  localparam logic CFG_HEADER_SIZE = 1'b1;

  typedef struct packed {
    logic                 we_start;
    logic                 we_len;
    logic [SEG_IDX_W-1:0] idx;
    logic [15:0]          start;
    logic [16:0]          length;
  } seg_wr_t;

  typedef struct packed {
    logic                 set;
    logic                 clr;
    logic                 clr_all;
    logic [BLK_IDX_W-1:0] idx;
    logic [15:0]          start;
    logic [16:0]          length;
    logic [4:0]           flags;
  } blk_wr_t;

endpackage

// ===== sv/ffca_seg_table.sv =====
// ----------------------------------------------------------------------------
// Free segment table
// Address-ordered start and length registers with one read and one write
// port; entry 0 covers the whole default pool after reset.
// ----------------------------------------------------------------------------
module ffca_seg_table (
  input  logic                    clk,
  input  logic                    rst,
  input  ffca_pkg::seg_wr_t       wr,
  input  logic [ffca_pkg::SEG_IDX_W-1:0] rd_idx,
  output logic [15:0]             rd_start,
  output logic [16:0]             rd_len
);
  import ffca_pkg::*;

  logic [15:0] seg_start  [FREE_ENTRIES];
  logic [16:0] seg_length [FREE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start[0]  <= '0;
      seg_length[0] <= 17'(MAX_POOL_BYTES);
    end else begin
      if (wr.we_start) seg_start[wr.idx] <= wr.start;
      if (wr.we_len) seg_length[wr.idx] <= wr.length;
    end
  end

  assign rd_start = seg_start[rd_idx];
  assign rd_len   = seg_length[rd_idx];
endmodule

// ===== sv/ffca_blk_table.sv =====
// ----------------------------------------------------------------------------
// Block record table
// Start, length and flag records of live blocks with a valid bit each.
// ----------------------------------------------------------------------------
module ffca_blk_table (
  input  logic                    clk,
  input  logic                    rst,
  input  ffca_pkg::blk_wr_t       wr,
  input  logic [ffca_pkg::BLK_IDX_W-1:0] rd_idx,
  output logic [15:0]             rd_start,
  output logic [16:0]             rd_len,
  output logic [ffca_pkg::BLOCK_ENTRIES-1:0] valid
);
  import ffca_pkg::*;

  logic [15:0] blk_start     [BLOCK_ENTRIES];
  logic [16:0] blk_length    [BLOCK_ENTRIES];
  logic [4:0]  blk_flag_bits [BLOCK_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst || wr.clr_all) begin
      valid <= '0;
    end else if (wr.set) begin
      valid[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      valid[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      blk_start[wr.idx]     <= wr.start;
      blk_length[wr.idx]    <= wr.length;
      blk_flag_bits[wr.idx] <= wr.flags;
    end
  end

  assign rd_start = blk_start[rd_idx];
  assign rd_len   = blk_length[rd_idx];
endmodule

// ===== sv/first_fit_coalescing_allocator_top.sv =====
// ----------------------------------------------------------------------------
// First-fit coalescing allocator
// Allocate walks the free segments, then shifts when one is removed. Free
// searches the block records, walks the segments, then shifts when a segment
// is inserted or two merge. Initialize resets the tables; a zero request or
// unused opcode goes to the result. One item at a time; a result not yet
// taken holds the sequencer, and the next item is taken once it is idle again.
// Synchronous reset gives one free segment over 65536 bytes and no blocks.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] amount,
  input  logic [15:0] address,
  input  logic [3:0]  caller_flags,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] user_offset,
  output logic [16:0] block_bytes,
  output logic        resized,
  output logic [16:0] current_bytes,
  output logic [5:0]  live_blocks,
  output logic [31:0] total_allocated,
  output logic [31:0] total_freed
);
  import ffca_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_AFIND  = 4'd2;
  localparam logic [3:0] S_ACHK   = 4'd3;
  localparam logic [3:0] S_SHIFTL = 4'd4;
  localparam logic [3:0] S_FSRCH  = 4'd5;
  localparam logic [3:0] S_FPOS   = 4'd6;
  localparam logic [3:0] S_SHIFTR = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]           state;
  logic [16:0]          pool_size;
  logic [6:0]           header_size;
  logic [15:0]          addr;
  logic [3:0]           flags;
  logic [16:0]          total;
  logic [SEG_CNT_W-1:0] seg_count;
  logic [SEG_CNT_W-1:0] i;
  logic [SEG_CNT_W-1:0] k;
  logic [BLK_IDX_W-1:0] r;
  logic [BLK_IDX_W-1:0] fr;
  logic [15:0]          bs;
  logic [16:0]          bl;
  logic [16:0]          be;
  logic [16:0]          prev_end;
  logic [16:0]          prev_len;
  logic [16:0]          held_bytes;
  logic [5:0]           live_total;
  logic [31:0]          sum_allocated;
  logic [31:0]          sum_freed;
  logic [2:0]           res_status;
  logic [15:0]          res_uoff;
  logic [16:0]          res_bytes;
  logic                 res_rsz;

  seg_wr_t              seg_wr;
  blk_wr_t              blk_wr;
  logic [SEG_IDX_W-1:0] seg_rd_idx;
  logic [15:0]          seg_rd_start;
  logic [16:0]          seg_rd_len;
  logic [15:0]          blk_rd_start;
  logic [16:0]          blk_rd_len;
  logic [BLOCK_ENTRIES-1:0] blk_valid;

  logic [BLK_IDX_W-1:0] free_idx;
  logic                 free_found;
  logic [16:0]          rem;
  logic                 small_rem;
  logic [16:0]          grant;
  logic                 blk_match;
  logic                 pos_stop;
  logic                 mprev;
  logic                 mnext;
  logic [16:0]          pool_eff;
  logic                 shl_more;
  logic                 shr_more;

  ffca_seg_table u_seg (
    .clk      (clk),
    .rst      (rst),
    .wr       (seg_wr),
    .rd_idx   (seg_rd_idx),
    .rd_start (seg_rd_start),
    .rd_len   (seg_rd_len)
  );

  ffca_blk_table u_blk (
    .clk      (clk),
    .rst      (rst),
    .wr       (blk_wr),
    .rd_idx   (r),
    .rd_start (blk_rd_start),
    .rd_len   (blk_rd_len),
    .valid    (blk_valid)
  );

  assign in_ready = (state == S_IDLE);

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int j = BLOCK_ENTRIES - 1; j >= 0; j--) begin
      if (!blk_valid[j]) begin
        free_idx   = BLK_IDX_W'(j);
        free_found = 1'b1;
      end
    end
  end

  assign rem       = seg_rd_len - total;
  assign small_rem = (rem <= {10'd0, header_size});
  assign grant     = small_rem ? seg_rd_len : total;
  assign blk_match = blk_valid[r] &&
                     (({1'b0, blk_rd_start} + {10'd0, header_size}) == {1'b0, addr});
  assign pos_stop  = (i >= seg_count) || ({1'b0, seg_rd_start} >= be);
  assign mprev     = (i != '0) && (prev_end == {1'b0, bs});
  assign mnext     = (i < seg_count) && ({1'b0, seg_rd_start} == be);
  assign pool_eff  = (pool_size > 17'(MAX_POOL_BYTES)) ? 17'(MAX_POOL_BYTES) : pool_size;
  assign shl_more  = ((k + 1'b1) < seg_count);
  assign shr_more  = (k > i);

  always_comb begin
    unique case (state)
      S_SHIFTL: seg_rd_idx = SEG_IDX_W'(k + 1'b1);
      S_SHIFTR: seg_rd_idx = SEG_IDX_W'(k - 1'b1);
      default:  seg_rd_idx = i[SEG_IDX_W-1:0];
    endcase
  end

  always_comb begin
    seg_wr = '0;
    blk_wr = '0;
    blk_wr.idx   = fr;
    blk_wr.start = seg_rd_start;
    blk_wr.length = grant;
    blk_wr.flags = {small_rem, flags};
    unique case (state)
      S_INIT: begin
        seg_wr.we_start = 1'b1;
        seg_wr.we_len   = 1'b1;
        seg_wr.idx      = '0;
        seg_wr.start    = '0;
        seg_wr.length   = pool_eff;
        blk_wr.clr_all  = 1'b1;
      end
      S_ACHK: begin
        if (free_found) begin
          blk_wr.set = 1'b1;
          blk_wr.idx = free_idx;
          if (!small_rem) begin
            seg_wr.we_start = 1'b1;
            seg_wr.we_len   = 1'b1;
            seg_wr.idx      = i[SEG_IDX_W-1:0];
            seg_wr.start    = seg_rd_start + total[15:0];
            seg_wr.length   = rem;
          end
        end
      end
      S_SHIFTL: begin
        if (shl_more) begin
          seg_wr.we_start = 1'b1;
          seg_wr.we_len   = 1'b1;
          seg_wr.idx      = k[SEG_IDX_W-1:0];
          seg_wr.start    = seg_rd_start;
          seg_wr.length   = seg_rd_len;
        end
      end
      S_SHIFTR: begin
        seg_wr.we_start = 1'b1;
        seg_wr.we_len   = 1'b1;
        if (shr_more) begin
          seg_wr.idx    = k[SEG_IDX_W-1:0];
          seg_wr.start  = seg_rd_start;
          seg_wr.length = seg_rd_len;
        end else begin
          seg_wr.idx    = i[SEG_IDX_W-1:0];
          seg_wr.start  = bs;
          seg_wr.length = bl;
        end
      end
      S_FPOS: begin
        blk_wr.idx = r;
        if (pos_stop) begin
          if (mprev) begin
            seg_wr.we_len = 1'b1;
            seg_wr.idx    = SEG_IDX_W'(i - 1'b1);
            seg_wr.length = mnext ? (prev_len + bl + seg_rd_len) : (prev_len + bl);
            blk_wr.clr    = 1'b1;
          end else if (mnext) begin
            seg_wr.we_start = 1'b1;
            seg_wr.we_len   = 1'b1;
            seg_wr.idx      = i[SEG_IDX_W-1:0];
            seg_wr.start    = bs;
            seg_wr.length   = seg_rd_len + bl;
            blk_wr.clr      = 1'b1;
          end else if (seg_count < SEG_CNT_W'(FREE_ENTRIES)) begin
            blk_wr.clr = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= 17'(MAX_POOL_BYTES);
      header_size <= 7'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_SIZE:   pool_size   <= cfg_data;
        CFG_HEADER_SIZE: header_size <= cfg_data[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seg_count     <= SEG_CNT_W'(1);
      held_bytes    <= '0;
      live_total    <= '0;
      sum_allocated <= '0;
      sum_freed     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            addr       <= address;
            flags      <= caller_flags;
            total      <= {1'b0, amount} + {10'd0, header_size};
            i          <= '0;
            r          <= '0;
            res_status <= ST_OK;
            res_uoff   <= '0;
            res_bytes  <= '0;
            res_rsz    <= 1'b0;
            if (opcode == OP_ALLOC) begin
              if (amount == '0) begin
                res_status <= ST_ZERO;
                state      <= S_DONE;
              end else begin
                state <= S_AFIND;
              end
            end else if (opcode == OP_FREE) begin
              state <= S_FSRCH;
            end else if (opcode == OP_INIT) begin
              state <= S_INIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_INIT: begin
          seg_count     <= (pool_eff != '0) ? SEG_CNT_W'(1) : '0;
          held_bytes    <= '0;
          live_total    <= '0;
          sum_allocated <= '0;
          sum_freed     <= '0;
          state         <= S_DONE;
        end
        S_AFIND: begin
          if (i >= seg_count) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else if (seg_rd_len >= total) begin
            state <= S_ACHK;
          end else begin
            i <= i + 1'b1;
          end
        end
        S_ACHK: begin
          if (!free_found) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            fr            <= free_idx;
            held_bytes    <= held_bytes + grant;
            live_total    <= live_total + 1'b1;
            sum_allocated <= sum_allocated + {15'd0, grant};
            res_uoff      <= seg_rd_start + {9'd0, header_size};
            res_bytes     <= grant;
            res_rsz       <= small_rem;
            k             <= i;
            state         <= small_rem ? S_SHIFTL : S_DONE;
          end
        end
        S_SHIFTL: begin
          if (shl_more) begin
            k <= k + 1'b1;
          end else begin
            if (seg_count != '0) seg_count <= seg_count - 1'b1;
            state <= S_DONE;
          end
        end
        S_FSRCH: begin
          if (blk_match) begin
            bs    <= blk_rd_start;
            bl    <= blk_rd_len;
            be    <= {1'b0, blk_rd_start} + blk_rd_len;
            state <= S_FPOS;
          end else if (r == BLK_IDX_W'(BLOCK_ENTRIES - 1)) begin
            res_status <= ST_UNKNOWN;
            state      <= S_DONE;
          end else begin
            r <= r + 1'b1;
          end
        end
        S_FPOS: begin
          if (!pos_stop) begin
            prev_end <= {1'b0, seg_rd_start} + seg_rd_len;
            prev_len <= seg_rd_len;
            i        <= i + 1'b1;
          end else if (!mprev && !mnext && seg_count >= SEG_CNT_W'(FREE_ENTRIES)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            held_bytes <= held_bytes - bl;
            if (live_total != '0) live_total <= live_total - 1'b1;
            sum_freed <= sum_freed + {15'd0, bl};
            res_bytes <= bl;
            if (mprev && mnext) begin
              k     <= i;
              state <= S_SHIFTL;
            end else if (mprev || mnext) begin
              state <= S_DONE;
            end else begin
              k     <= seg_count;
              state <= S_SHIFTR;
            end
          end
        end
        S_SHIFTR: begin
          if (shr_more) begin
            k <= k - 1'b1;
          end else begin
            seg_count <= seg_count + 1'b1;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            status          <= res_status;
            user_offset     <= res_uoff;
            block_bytes     <= res_bytes;
            resized         <= res_rsz;
            current_bytes   <= held_bytes;
            live_blocks     <= live_total;
            total_allocated <= sum_allocated;
            total_freed     <= sum_freed;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    seg_count <= SEG_CNT_W'(FREE_ENTRIES))
    else $error("free segment count above table depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (32'(live_total) == 32'($countones(blk_valid))))
    else $error("live block count disagrees with record valid bits");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result presented outside the completion step");

endmodule
